// ===== src/cdsq_pkg.sv =====
// Shared types, codes and helpers for the CD subcode Q decoder.
package cdsq_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_READING_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CD_DISC_TYPE   = 1'd1;

    // Address mode codes (low nibble of control/address)
    localparam logic [3:0] ADDR_POSITION = 4'h1;
    localparam logic [3:0] ADDR_CATALOG  = 4'h2;
    localparam logic [3:0] ADDR_ISRC     = 4'h3;
    localparam logic [3:0] ADDR_AREA     = 4'h5;
    localparam logic [1:0] ADDR_LO2_POS  = 2'b01;

    // Special byte codes
    localparam logic [7:0] TRACK_LEAD_OUT = 8'hAA;
    localparam logic [7:0] POINT_A0       = 8'hA0;
    localparam logic [7:0] POINT_A1       = 8'hA1;
    localparam logic [7:0] POINT_A2       = 8'hA2;
    localparam logic [7:0] POINT_B0       = 8'hB0;
    localparam logic [7:0] MIN_NONE       = 8'hFF;
    localparam logic [7:0] LEAD_IN_MIN    = 8'd90;

    // match_flags bit positions
    localparam int unsigned FLG_ANY      = 0;
    localparam int unsigned FLG_ABS_TIME = 1;
    localparam int unsigned FLG_CATALOG  = 2;
    localparam int unsigned FLG_ISRC     = 3;
    localparam int unsigned FLG_FIRST_LI = 4;
    localparam int unsigned FLG_LEAD_IN  = 5;
    localparam int unsigned FLG_PROGRAM  = 6;
    localparam int unsigned FLG_LEAD_OUT = 7;

    typedef struct packed {
        logic [7:0] control_address;
        logic [7:0] track_bcd;
        logic [7:0] index_bcd;
        logic [7:0] rel_min_in;
        logic [7:0] rel_sec_in;
        logic [7:0] rel_frame_in;
        logic [7:0] abs_min_in;
        logic [7:0] abs_sec_in;
        logic [7:0] abs_frame_in;
    } cdsq_in_t;

    typedef struct packed {
        logic [7:0] track_out;
        logic [7:0] index_out;
        logic [7:0] rel_min_out;
        logic [7:0] rel_sec_out;
        logic [7:0] rel_frame_out;
        logic [7:0] abs_min_out;
        logic [7:0] abs_sec_out;
        logic [7:0] abs_frame_out;
        logic [7:0] brake_minute;
        logic [7:0] match_flags;
    } cdsq_out_t;

    // high*10 + low, no digit check; max 165 fits in 8 bits
    function automatic logic [7:0] bcd_bin(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

endpackage

// ===== src/cdsq_decode.sv =====
// Combinational decode of one Q-subchannel frame.
module cdsq_decode (
    input  cdsq_pkg::cdsq_in_t  frame,
    input  logic                disc_type,
    output cdsq_pkg::cdsq_out_t result
);
    import cdsq_pkg::*;

    logic [3:0] addr;
    logic [7:0] trk;
    logic [7:0] idx;
    logic [7:0] rm;
    logic [7:0] rs;
    logic [7:0] rf;
    logic [7:0] am;
    logic [7:0] as_v;
    logic [7:0] af;
    logic [7:0] brake;
    logic [7:0] flags;

    assign addr = frame.control_address[3:0];

    always_comb begin
        trk   = frame.track_bcd;
        idx   = frame.index_bcd;
        rm    = frame.rel_min_in;
        rs    = frame.rel_sec_in;
        rf    = frame.rel_frame_in;
        am    = frame.abs_min_in;
        as_v  = frame.abs_sec_in;
        af    = frame.abs_frame_in;
        brake = 8'd0;

        if (addr == ADDR_POSITION) begin
            if (frame.track_bcd != TRACK_LEAD_OUT) begin
                trk = bcd_bin(frame.track_bcd);
            end
            rm = bcd_bin(frame.rel_min_in);
            rs = bcd_bin(frame.rel_sec_in);
            rf = bcd_bin(frame.rel_frame_in);
            am = bcd_bin(frame.abs_min_in);
            if (frame.index_bcd != POINT_A0 && frame.index_bcd != POINT_A1) begin
                as_v = bcd_bin(frame.abs_sec_in);
                af   = bcd_bin(frame.abs_frame_in);
                if (frame.index_bcd != POINT_A2) begin
                    idx = bcd_bin(frame.index_bcd);
                end
            end
            if (trk != 8'd0) begin
                brake = am;
            end
        end else if (addr == ADDR_AREA) begin
            if (frame.track_bcd == 8'd0 && frame.index_bcd == POINT_B0 &&
                frame.rel_min_in != MIN_NONE) begin
                rm = bcd_bin(frame.rel_min_in);
                rs = bcd_bin(frame.rel_sec_in);
                rf = bcd_bin(frame.rel_frame_in);
            end
        end
    end

    // Classification runs on the converted track and minute
    always_comb begin
        flags = 8'd0;
        flags[FLG_ANY] = 1'b1;
        if (addr == ADDR_POSITION) begin
            if (trk != 8'd0) begin
                flags[FLG_ABS_TIME] = 1'b1;
            end else if (rm > LEAD_IN_MIN || disc_type) begin
                flags[FLG_FIRST_LI] = 1'b1;
            end else begin
                flags[FLG_ABS_TIME] = 1'b1;
            end
            flags[FLG_PROGRAM]  = (trk != 8'd0) && (trk != TRACK_LEAD_OUT);
            flags[FLG_LEAD_OUT] = (trk == TRACK_LEAD_OUT);
        end
        flags[FLG_CATALOG] = (addr == ADDR_CATALOG);
        flags[FLG_ISRC]    = (addr == ADDR_ISRC);
        flags[FLG_LEAD_IN] = (frame.control_address[1:0] == ADDR_LO2_POS) && (trk == 8'd0);
    end

    always_comb begin
        result.track_out     = trk;
        result.index_out     = idx;
        result.rel_min_out   = rm;
        result.rel_sec_out   = rs;
        result.rel_frame_out = rf;
        result.abs_min_out   = am;
        result.abs_sec_out   = as_v;
        result.abs_frame_out = af;
        result.brake_minute  = brake;
        result.match_flags   = flags;
    end

endmodule

// ===== src/cd_subcode_q_decoder.sv =====
// Top level of the CD subcode Q decoder: config registers, handshake, result register.
//
// Input channel s_valid/s_ready/s_data carries one Q-subchannel frame per item.
// Output channel m_valid/m_ready/m_data carries the decoded frame, the braking
// minute and eight query-mode match flags.
// Each item is decoded in one pass of combinational logic and lands in the
// result register, so a result appears in the cycle after its item is accepted.
// Throughput is one item per cycle while the receiver does not stall; the single result register sets it.
// When reading_enable is clear, items are still accepted but produce no result.
// When the receiver stalls, the held result stays on m_data and s_ready drops
// until it is taken; in the cycle it is taken a new item can be accepted.
// cfg_wr_en writes cfg_wdata into register cfg_addr (0: reading_enable,
// 1: cd_disc_type) at the clock edge; write only while the block is idle.
// Synchronous active-low reset clears both registers and drops m_valid.
module cd_subcode_q_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cdsq_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [cdsq_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cdsq_pkg::cdsq_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cdsq_pkg::cdsq_out_t                 m_data
);
    import cdsq_pkg::*;

    logic      reading_enable_reg;
    logic      disc_type_reg;
    logic      m_valid_reg;
    logic      m_valid_next;
    cdsq_out_t m_data_reg;
    cdsq_out_t decoded;
    logic      s_accept;

    cdsq_decode u_decode (
        .frame     (s_data),
        .disc_type (disc_type_reg),
        .result    (decoded)
    );

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept && reading_enable_reg) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reading_enable_reg <= 1'b0;
            disc_type_reg      <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_READING_ENABLE: reading_enable_reg <= cfg_wdata[0];
                    REG_CD_DISC_TYPE:   disc_type_reg      <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && reading_enable_reg) begin
            m_data_reg <= decoded;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/cdsq_checker.sv =====
// Port-level checks for the CD subcode Q decoder, bound to the top level.
module cdsq_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input cdsq_pkg::cdsq_out_t m_data
);
    import cdsq_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a pending result that is not taken blocks new items
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("item accepted over stalled result");

    // braking minute only on position frames in the program/lead-out area
    a_brake: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.brake_minute != 8'd0 |->
            m_data.match_flags[FLG_ANY] && m_data.match_flags[FLG_ABS_TIME] &&
            !m_data.match_flags[FLG_FIRST_LI] && !m_data.match_flags[FLG_LEAD_IN])
        else $error("brake minute on wrong frame class");

    a_class: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.match_flags[FLG_PROGRAM] && m_data.match_flags[FLG_LEAD_OUT]))
        else $error("program and lead-out both flagged");

endmodule

bind cd_subcode_q_decoder cdsq_checker u_cdsq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
